// ===== rtl/smx_pkg.sv =====
// ----------------------------------------------------------------------------
// smx_pkg
// Shared types and constants of the stack machine executor.
// ----------------------------------------------------------------------------
package smx_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int VAR_COUNT   = 64;
    localparam int FRAC_BITS   = 32;

    localparam int DATA_W = 64;
    localparam int OP_W   = 3;
    localparam int VIDX_W = 6;
    localparam int STAT_W = 3;
    localparam int SP_W   = $clog2(STACK_DEPTH + 1);
    localparam int STK_AW = $clog2(STACK_DEPTH);
    localparam int VAR_AW = $clog2(VAR_COUNT);

    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 3'd0,
        OP_LOAD  = 3'd1,
        OP_STORE = 3'd2,
        OP_ADD   = 3'd3,
        OP_SUB   = 3'd4,
        OP_MUL   = 3'd5,
        OP_DIV   = 3'd6,
        OP_PRINT = 3'd7
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 3'd0,
        ST_UNDEF = 3'd1,
        ST_UFLOW = 3'd2,
        ST_DIV0  = 3'd3,
        ST_OFLOW = 3'd4,
        ST_SKIP  = 3'd5
    } t_status;

    typedef struct packed {
        logic start;
        logic is_div;
    } t_md_req;

    typedef struct packed {
        logic done;
        logic sat;
    } t_md_rsp;

endpackage

// ===== rtl/smx_if.sv =====
// ----------------------------------------------------------------------------
// smx_in_if / smx_out_if
// Valid/ready channels carrying instructions and results.
// ----------------------------------------------------------------------------
interface smx_in_if;
    logic                        valid;
    logic                        ready;
    logic [smx_pkg::OP_W-1:0]    op;
    logic signed [63:0]          const_value;
    logic [smx_pkg::VIDX_W-1:0]  var_index;
    logic                        first_of_statement;

    modport source (output valid, op, const_value, var_index, first_of_statement,
                    input ready);
    modport sink   (input valid, op, const_value, var_index, first_of_statement,
                    output ready);
endinterface

interface smx_out_if;
    logic                        valid;
    logic                        ready;
    logic [smx_pkg::STAT_W-1:0]  status;
    logic                        print_valid;
    logic signed [63:0]          print_value;
    logic signed [63:0]          top_value;
    logic                        saturated;

    modport source (output valid, status, print_valid, print_value, top_value, saturated,
                    input ready);
    modport sink   (input valid, status, print_valid, print_value, top_value, saturated,
                    output ready);
endinterface

// ===== rtl/smx_muldiv.sv =====
// ----------------------------------------------------------------------------
// smx_muldiv
// Shared iterative fixed-point multiplier (shift-add, one bit a cycle) and
// restoring divider (one quotient bit a cycle), with saturation.
// ----------------------------------------------------------------------------
module smx_muldiv (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  smx_pkg::t_md_req           i_req,
    input  logic [smx_pkg::DATA_W-1:0] i_a,
    input  logic [smx_pkg::DATA_W-1:0] i_b,
    output smx_pkg::t_md_rsp           o_rsp,
    output logic [smx_pkg::DATA_W-1:0] o_result
);
    import smx_pkg::*;

    localparam int CNT_W = 8;
    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(DATA_W - 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(2 * DATA_W - 1);
    localparam logic [DATA_W-1:0] MAXP = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] MINN = {1'b1, {(DATA_W-1){1'b0}}};

    logic                  r_busy, r_fin, r_div, r_neg;
    logic [CNT_W-1:0]      r_cnt;
    logic [2*DATA_W-1:0]   r_acc;
    logic [DATA_W-1:0]     r_rem;
    logic [DATA_W-1:0]     r_y;

    logic [DATA_W-1:0]     mag_a, mag_b;
    logic [DATA_W:0]       madd;
    logic [DATA_W:0]       dtry;
    logic                  dge;
    logic [2*DATA_W-1:0]   q;
    logic                  over;

    assign mag_a = i_a[DATA_W-1] ? (~i_a + 1'b1) : i_a;
    assign mag_b = i_b[DATA_W-1] ? (~i_b + 1'b1) : i_b;

    // adder for the multiply, trial compare and subtract for the divide
    assign madd = {1'b0, r_acc[2*DATA_W-1:DATA_W]} + (r_acc[0] ? {1'b0, r_y} : '0);
    assign dtry = {r_rem, r_acc[2*DATA_W-1]};
    assign dge  = dtry >= {1'b0, r_y};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_fin <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == (r_div ? DIV_LAST : MUL_LAST)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_div <= i_req.is_div;
            r_neg <= i_a[DATA_W-1] ^ i_b[DATA_W-1];
            r_y   <= mag_b;
            r_rem <= '0;
            r_acc <= i_req.is_div ? ({{DATA_W{1'b0}}, mag_a} << FRAC_BITS)
                                  : {{DATA_W{1'b0}}, mag_a};
        end else if (r_busy) begin
            if (r_div) begin
                r_rem <= dge ? DATA_W'(dtry - {1'b0, r_y}) : dtry[DATA_W-1:0];
                r_acc <= {r_acc[2*DATA_W-2:0], dge};
            end else begin
                r_acc <= {madd, r_acc[DATA_W-1:1]};
            end
        end
    end

    assign q = r_div ? r_acc : (r_acc >> FRAC_BITS);

    always_comb begin
        if (!r_neg) begin
            over     = (q[2*DATA_W-1:DATA_W] != '0) || (q[DATA_W-1:0] > MAXP);
            o_result = over ? MAXP : q[DATA_W-1:0];
        end else begin
            over     = (q[2*DATA_W-1:DATA_W] != '0) || (q[DATA_W-1:0] > MINN);
            o_result = over ? MINN : (~q[DATA_W-1:0] + 1'b1);
        end
    end

    assign o_rsp.done = r_fin;
    assign o_rsp.sat  = over;

endmodule

// ===== rtl/stack_machine_executor_unit.sv =====
// ----------------------------------------------------------------------------
// stack_machine_executor_unit
// Executes stack-machine instructions on signed Q32.32 values.
// ----------------------------------------------------------------------------
// One instruction is taken per beat and yields one result beat. Push, load,
// store, print, add and sub raise result valid after the memory read and
// execute states; mul and div that reach the unit also wait in a busy state on
// the shared one-bit-per-cycle multiply/divide unit. The input is not ready
// from acceptance until the result beat is taken. The top of stack is held in
// a register; lower entries and the variables sit in memories with registered
// reads. Variable valid bits are cleared at reset, no clearing pass.
module stack_machine_executor_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    smx_in_if.sink    i_in,
    smx_out_if.source o_out
);
    import smx_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_EXEC = 5'b00100,
        S_BUSY = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    localparam logic [DATA_W-1:0] MAXP = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] MINN = {1'b1, {(DATA_W-1){1'b0}}};

    t_state              r_state, n_state;
    t_op                 r_op;
    logic [DATA_W-1:0]   r_cval;
    logic [VIDX_W-1:0]   r_idx;
    logic [SP_W-1:0]     r_sp, n_sp;
    logic                r_err, n_err;
    logic [DATA_W-1:0]   r_tos, n_tos;
    logic [DATA_W-1:0]   r_nos, r_vrd;
    t_status             r_status, n_status;
    logic                r_pvld, n_pvld;
    logic [DATA_W-1:0]   r_pval, n_pval;
    logic                r_sat, n_sat;
    logic [VAR_COUNT-1:0] r_vvld;

    logic [DATA_W-1:0]   r_stk [STACK_DEPTH];
    logic [DATA_W-1:0]   r_var [VAR_COUNT];

    logic                stk_we, var_we;
    logic [STK_AW-1:0]   stk_wa, stk_ra;
    logic                idx_ok;
    logic [DATA_W-1:0]   sum, dif;
    logic                sum_ov, dif_ov;
    t_md_req             md_req;
    t_md_rsp             md_rsp;
    logic [DATA_W-1:0]   md_res;

    smx_muldiv u_md (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (md_req),
        .i_a      (r_nos),
        .i_b      (r_tos),
        .o_rsp    (md_rsp),
        .o_result (md_res)
    );

    assign idx_ok = 32'(r_idx) < VAR_COUNT;
    assign stk_ra = STK_AW'(r_sp - SP_W'(2));
    assign stk_wa = STK_AW'(r_sp - SP_W'(1));

    assign sum    = r_nos + r_tos;
    assign dif    = r_nos - r_tos;
    assign sum_ov = (r_nos[DATA_W-1] == r_tos[DATA_W-1]) && (sum[DATA_W-1] != r_nos[DATA_W-1]);
    assign dif_ov = (r_nos[DATA_W-1] != r_tos[DATA_W-1]) && (dif[DATA_W-1] != r_nos[DATA_W-1]);

    always_comb begin
        n_state  = r_state;
        n_sp     = r_sp;
        n_err    = r_err;
        n_tos    = r_tos;
        n_status = r_status;
        n_pvld   = r_pvld;
        n_pval   = r_pval;
        n_sat    = r_sat;
        stk_we   = 1'b0;
        var_we   = 1'b0;
        md_req   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    if (i_in.first_of_statement) begin
                        n_sp  = '0;
                        n_err = 1'b0;
                    end
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_status = ST_OK;
                n_pvld   = 1'b0;
                n_pval   = '0;
                n_sat    = 1'b0;
                n_state  = S_OUT;
                if (r_err) begin
                    n_status = ST_SKIP;
                end else begin
                    case (r_op)
                        OP_PUSH, OP_LOAD: begin
                            if (r_op == OP_LOAD && (!idx_ok || !r_vvld[VAR_AW'(r_idx)])) begin
                                n_status = ST_UNDEF;
                            end else if (r_sp >= SP_W'(STACK_DEPTH)) begin
                                n_status = ST_OFLOW;
                            end else begin
                                stk_we = r_sp != '0;
                                n_tos  = (r_op == OP_LOAD) ? r_vrd : r_cval;
                                n_sp   = r_sp + 1'b1;
                            end
                        end
                        OP_STORE, OP_PRINT: begin
                            if (r_sp == '0) begin
                                n_status = ST_UFLOW;
                            end else if (r_op == OP_STORE) begin
                                var_we = idx_ok;
                            end else begin
                                n_pvld = 1'b1;
                                n_pval = r_tos;
                                n_tos  = r_nos;
                                n_sp   = r_sp - 1'b1;
                            end
                        end
                        default: begin
                            if (r_sp < SP_W'(2)) begin
                                n_status = ST_UFLOW;
                            end else if (r_op == OP_ADD) begin
                                n_sat = sum_ov;
                                n_tos = sum_ov ? (r_nos[DATA_W-1] ? MINN : MAXP) : sum;
                                n_sp  = r_sp - 1'b1;
                            end else if (r_op == OP_SUB) begin
                                n_sat = dif_ov;
                                n_tos = dif_ov ? (r_nos[DATA_W-1] ? MINN : MAXP) : dif;
                                n_sp  = r_sp - 1'b1;
                            end else if (r_op == OP_DIV && r_tos == '0) begin
                                n_status = ST_DIV0;
                            end else begin
                                md_req.start  = 1'b1;
                                md_req.is_div = r_op == OP_DIV;
                                n_state       = S_BUSY;
                            end
                        end
                    endcase
                    if (n_status != ST_OK) begin
                        n_err = 1'b1;
                    end
                end
            end
            S_BUSY: begin
                if (md_rsp.done) begin
                    n_tos   = md_res;
                    n_sat   = md_rsp.sat;
                    n_sp    = r_sp - 1'b1;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (o_out.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sp    <= '0;
            r_err   <= 1'b0;
            r_vvld  <= '0;
        end else begin
            r_state <= n_state;
            r_sp    <= n_sp;
            r_err   <= n_err;
            if (var_we) begin
                r_vvld[VAR_AW'(r_idx)] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tos    <= n_tos;
        r_status <= n_status;
        r_pvld   <= n_pvld;
        r_pval   <= n_pval;
        r_sat    <= n_sat;
        if (r_state == S_IDLE) begin
            r_op   <= t_op'(i_in.op);
            r_cval <= i_in.const_value;
            r_idx  <= i_in.var_index;
        end
    end

    // stack below the top, registered read of the second entry
    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stk[stk_wa] <= r_tos;
        end
        r_nos <= r_stk[stk_ra];
    end

    always_ff @(posedge i_clk) begin
        if (var_we) begin
            r_var[VAR_AW'(r_idx)] <= r_tos;
        end
        r_vrd <= r_var[VAR_AW'(r_idx)];
    end

    assign i_in.ready        = r_state == S_IDLE;
    assign o_out.valid       = r_state == S_OUT;
    assign o_out.status      = r_status;
    assign o_out.print_valid = r_pvld;
    assign o_out.print_value = r_pval;
    assign o_out.top_value   = (r_sp != '0) ? r_tos : '0;
    assign o_out.saturated   = r_sat;

`ifndef SYNTHESIS
    a_sp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SP_W'(STACK_DEPTH))
        else $error("stack pointer beyond depth");

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid))
        else $error("input ready while result pending");

    a_print_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.print_valid || o_out.saturated) |-> o_out.status == ST_OK)
        else $error("print or saturation flagged on a failed beat");

    a_md_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        md_rsp.done |-> r_state == S_BUSY)
        else $error("mul/div completion outside busy state");
`endif

endmodule
